>>> rtl/cdaa_pkg.sv
// Shared types and codes for the dynamic address allocator.
// No dependencies; used by cdaa_cmp_unit and chiplet_dynamic_address_allocator.
`timescale 1ns / 1ps
package cdaa_pkg;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_OOM    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NOPEND = 2'd3;

    localparam logic [1:0] CFG_RAM_KIB = 2'd0;
    localparam logic [1:0] CFG_FLIT_PB = 2'd1;

    localparam logic [21:0] RAM_KIB_RST = 22'd1024;
    localparam logic [8:0]  FLIT_PB_RST = 9'd32;

    // one table entry against the current scan context
    typedef struct packed {
        logic        vld;
        logic [31:0] start;
        logic [31:0] key;
        logic [31:0] base;
        logic [31:0] last;
        logic        have;
        logic        pick_vld;
        logic [31:0] pick_start;
    } t_cmp_req;

    typedef struct packed {
        logic cand;
        logic hit;
        logic empty;
    } t_cmp_rsp;

endpackage

>>> rtl/cdaa_cmp_unit.sv
// Shared compare unit: classifies one table entry per cycle.
// Depends on cdaa_pkg.
`timescale 1ns / 1ps
module cdaa_cmp_unit (
    input  cdaa_pkg::t_cmp_req i_req,
    output cdaa_pkg::t_cmp_rsp o_rsp
);
    always_comb begin
        // first-fit candidate: lowest start above the last visited one
        o_rsp.cand  = i_req.vld && (i_req.start >= i_req.base)
                      && (!i_req.have || (i_req.start > i_req.last))
                      && (!i_req.pick_vld || (i_req.start < i_req.pick_start));
        o_rsp.hit   = i_req.vld && (i_req.start == i_req.key);
        o_rsp.empty = !i_req.vld;
    end
endmodule

>>> rtl/chiplet_dynamic_address_allocator.sv
// Top level of the dynamic address allocator: sequencer, range and pending tables.
// Depends on cdaa_pkg and cdaa_cmp_unit.
`timescale 1ns / 1ps
// One transaction is taken when i_start is high while o_busy is low; its result
// appears on o_out_address, o_out_dest_node and o_status for exactly one cycle,
// marked by o_done, and must be captured then since the receiver cannot stall.
// A single compare unit visits one table entry per cycle. Fixed-address writes
// go straight to the result (on-chip flit-marked ones are placed). Reads make one
// free scan of the range table; later flits scan the pending table. A dynamic
// placement scans the range table once per range stepped over in the first-fit
// walk and once more, then for a slot; an off-chip first flit also scans the pending table.
// No clearing pass is needed after reset: valid bits reset at once.
module chiplet_dynamic_address_allocator #(
    parameter int RANGE_ENTRIES   = 32,
    parameter int PENDING_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [21:0] i_cfg_wdata,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_opcode,
    input  logic [31:0] i_req_address,
    input  logic [15:0] i_data_length,
    input  logic        i_source_valid,
    input  logic [7:0]  i_source_node,
    input  logic [7:0]  i_dest_node,
    input  logic        i_fixed_addr,
    input  logic        i_flit_valid,
    input  logic [7:0]  i_flit_index,
    input  logic [8:0]  i_flit_total,
    input  logic [15:0] i_request_tag,
    output logic        o_done,
    output logic [31:0] o_out_address,
    output logic [7:0]  o_out_dest_node,
    output logic [1:0]  o_status
);
    localparam int RW = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
    localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam logic [RW-1:0] R_LAST = RW'(RANGE_ENTRIES - 1);
    localparam logic [PW-1:0] P_LAST = PW'(PENDING_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FREE, S_PICK, S_STEP, S_SLOT, S_WRITE,
        S_PEND, S_PWR, S_LOOK, S_LFIN, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [21:0] r_ram_kib;
    logic [8:0]  r_flit_pb;

    // tables
    logic [31:0] r_rstart [RANGE_ENTRIES];
    logic [31:0] r_rlen   [RANGE_ENTRIES];
    logic        r_rvalid [RANGE_ENTRIES];
    logic [15:0] r_ptag   [PENDING_ENTRIES];
    logic [31:0] r_pbase  [PENDING_ENTRIES];
    logic        r_pvalid [PENDING_ENTRIES];

    // transaction context
    logic [RW-1:0] r_idx, r_rmatch, r_rfree;
    logic          r_rmatch_v, r_rfree_v;
    logic [PW-1:0] r_pidx, r_pmatch, r_pfree;
    logic          r_pmatch_v, r_pfree_v;
    logic [31:0]   r_hit_base;
    logic [31:0]   r_key;
    logic [31:0]   r_base;
    logic [31:0]   r_limit;
    logic [33:0]   r_addr;
    logic [17:0]   r_size;
    logic [31:0]   r_last;
    logic          r_have;
    logic          r_pick_vld;
    logic [31:0]   r_pick_start;
    logic [31:0]   r_pick_len;
    logic          r_off_flit;
    logic [15:0]   r_tag;
    logic [16:0]   r_foff;
    logic          r_retire;
    logic [31:0]   r_out_addr;
    logic [7:0]    r_out_dst;
    logic [1:0]    r_out_st;

    // derived sizes
    logic [30:0] half;
    logic [31:0] offaddr;
    logic        onchip;
    logic        accept;
    logic        scan_pend;
    logic [33:0] addr_end;
    logic        rfull;
    logic [RW-1:0] rslot;
    logic [PW-1:0] pslot;
    logic        pfull;

    cdaa_pkg::t_cmp_req cmp_req;
    cdaa_pkg::t_cmp_rsp cmp_rsp;

    assign half      = {r_ram_kib, 9'b0};
    assign offaddr   = i_req_address + {1'b0, half};
    assign onchip    = !i_source_valid || (i_source_node == i_dest_node);
    assign accept    = i_start && (r_state == S_IDLE);
    assign scan_pend = (r_state == S_PEND) || (r_state == S_LOOK);
    assign addr_end  = r_addr + {16'b0, r_size};
    assign rfull     = !r_rmatch_v && !r_rfree_v;
    assign rslot     = r_rmatch_v ? r_rmatch : r_rfree;
    assign pfull     = !r_pmatch_v && !r_pfree_v;
    assign pslot     = r_pmatch_v ? r_pmatch : r_pfree;

    // feed the shared compare unit from whichever table is being walked
    always_comb begin
        cmp_req.base       = r_base;
        cmp_req.last       = r_last;
        cmp_req.have       = r_have;
        cmp_req.pick_vld   = r_pick_vld;
        cmp_req.pick_start = r_pick_start;
        if (scan_pend) begin
            cmp_req.vld   = r_pvalid[r_pidx];
            cmp_req.start = {16'b0, r_ptag[r_pidx]};
            cmp_req.key   = {16'b0, r_tag};
        end else begin
            cmp_req.vld   = r_rvalid[r_idx];
            cmp_req.start = r_rstart[r_idx];
            cmp_req.key   = r_key;
        end
    end

    cdaa_cmp_unit u_cmp (
        .i_req (cmp_req),
        .o_rsp (cmp_rsp)
    );

    // table payload: no reset, written only while the valid bit is set alongside
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && !rfull) begin
            r_rstart[rslot] <= r_key;
            r_rlen[rslot]   <= {14'b0, r_size};
        end
        if (r_state == S_PWR && !pfull) begin
            r_ptag[pslot]  <= r_tag;
            r_pbase[pslot] <= r_key;
        end
    end

    // sequencer, valid bits and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ram_kib <= cdaa_pkg::RAM_KIB_RST;
            r_flit_pb <= cdaa_pkg::FLIT_PB_RST;
            for (int i = 0; i < RANGE_ENTRIES; i++) r_rvalid[i] <= 1'b0;
            for (int i = 0; i < PENDING_ENTRIES; i++) r_pvalid[i] <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cdaa_pkg::CFG_RAM_KIB: r_ram_kib <= i_cfg_wdata;
                    cdaa_pkg::CFG_FLIT_PB: r_flit_pb <= i_cfg_wdata[8:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_out_dst  <= i_dest_node;
                        r_out_st   <= cdaa_pkg::ST_OK;
                        r_out_addr <= i_req_address;
                        r_tag      <= i_request_tag;
                        r_idx      <= '0;
                        r_pidx     <= '0;
                        r_have     <= 1'b0;
                        r_pick_vld <= 1'b0;
                        r_rmatch_v <= 1'b0;
                        r_rfree_v  <= 1'b0;
                        r_pmatch_v <= 1'b0;
                        r_pfree_v  <= 1'b0;
                        r_foff     <= {9'b0, i_flit_index} * {8'b0, r_flit_pb};
                        r_retire   <= ({1'b0, i_flit_index} + 9'd1) == i_flit_total;
                        if (onchip) begin
                            r_base     <= '0;
                            r_limit    <= {1'b0, half};
                            r_addr     <= '0;
                            r_size     <= {2'b0, i_data_length};
                            r_off_flit <= 1'b0;
                            r_key      <= i_req_address;
                            if (i_opcode == cdaa_pkg::OP_READ) begin
                                r_state <= S_FREE;
                            end else if (i_flit_valid || !i_fixed_addr) begin
                                r_state <= S_PICK;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_base     <= {1'b0, half};
                            r_limit    <= {half, 1'b0};
                            r_addr     <= {3'b0, half};
                            r_size     <= {9'b0, i_flit_total} * {9'b0, r_flit_pb};
                            r_off_flit <= 1'b1;
                            r_key      <= offaddr;
                            r_out_addr <= offaddr;
                            if (i_opcode == cdaa_pkg::OP_READ) begin
                                r_out_dst <= i_source_node;
                                r_state   <= S_FREE;
                            end else if (i_fixed_addr) begin
                                r_state <= S_OUT;
                            end else if (i_flit_index == 8'd0) begin
                                r_state <= S_PICK;
                            end else begin
                                r_state <= S_LOOK;
                            end
                        end
                    end
                end
                S_FREE: begin
                    // drop every range that starts at the key
                    if (cmp_rsp.hit) r_rvalid[r_idx] <= 1'b0;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == R_LAST) r_state <= S_OUT;
                end
                S_PICK: begin
                    if (cmp_rsp.cand) begin
                        r_pick_vld   <= 1'b1;
                        r_pick_start <= r_rstart[r_idx];
                        r_pick_len   <= r_rlen[r_idx];
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == R_LAST) r_state <= S_STEP;
                end
                S_STEP: begin
                    r_idx <= '0;
                    if (!r_pick_vld || addr_end <= {2'b0, r_pick_start}) begin
                        r_key   <= r_addr[31:0];
                        r_state <= S_SLOT;
                    end else begin
                        // hop past the blocking range and rescan
                        r_addr     <= 34'({1'b0, r_pick_start} + {1'b0, r_pick_len});
                        r_last     <= r_pick_start;
                        r_have     <= 1'b1;
                        r_pick_vld <= 1'b0;
                        r_state    <= S_PICK;
                    end
                end
                S_SLOT: begin
                    if (cmp_rsp.hit && !r_rmatch_v) begin
                        r_rmatch_v <= 1'b1;
                        r_rmatch   <= r_idx;
                    end
                    if (cmp_rsp.empty && !r_rfree_v) begin
                        r_rfree_v <= 1'b1;
                        r_rfree   <= r_idx;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == R_LAST) r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_out_addr <= r_key;
                    if (rfull) begin
                        r_out_st <= cdaa_pkg::ST_FULL;
                    end else begin
                        r_rvalid[rslot] <= 1'b1;
                        r_out_st <= (addr_end > {2'b0, r_limit}) ? cdaa_pkg::ST_OOM
                                                                 : cdaa_pkg::ST_OK;
                    end
                    r_state <= r_off_flit ? S_PEND : S_OUT;
                end
                S_PEND: begin
                    if (cmp_rsp.hit && !r_pmatch_v) begin
                        r_pmatch_v <= 1'b1;
                        r_pmatch   <= r_pidx;
                    end
                    if (cmp_rsp.empty && !r_pfree_v) begin
                        r_pfree_v <= 1'b1;
                        r_pfree   <= r_pidx;
                    end
                    r_pidx <= r_pidx + 1'b1;
                    if (r_pidx == P_LAST) r_state <= S_PWR;
                end
                S_PWR: begin
                    if (pfull) r_out_st <= cdaa_pkg::ST_FULL;
                    else       r_pvalid[pslot] <= 1'b1;
                    r_state <= S_OUT;
                end
                S_LOOK: begin
                    if (cmp_rsp.hit && !r_pmatch_v) begin
                        r_pmatch_v <= 1'b1;
                        r_pmatch   <= r_pidx;
                        r_hit_base <= r_pbase[r_pidx];
                    end
                    r_pidx <= r_pidx + 1'b1;
                    if (r_pidx == P_LAST) r_state <= S_LFIN;
                end
                S_LFIN: begin
                    if (!r_pmatch_v) begin
                        r_out_st   <= cdaa_pkg::ST_NOPEND;
                        r_out_addr <= '0;
                    end else begin
                        r_out_addr <= r_hit_base + {15'b0, r_foff};
                        if (r_retire) r_pvalid[r_pmatch] <= 1'b0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = (r_state == S_OUT);
    assign o_out_address   = r_out_addr;
    assign o_out_dest_node = r_out_dst;
    assign o_status        = r_out_st;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !o_busy)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("accepted transaction did not raise busy");

    a_nopend_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == cdaa_pkg::ST_NOPEND |-> o_out_address == 32'd0)
        else $error("missing pending entry must return address zero");

endmodule

>>> tb/testbench.sv
// Self-checking bench for chiplet_dynamic_address_allocator: a queue-fed driver,
// a result monitor and a cycle-free predictor of the range and pending tables.
// Depends on cdaa_pkg and the allocator RTL.
`timescale 1ns / 1ps
module testbench;

    // One request transaction as presented on the input ports.
    typedef struct {
        logic        opcode;
        logic [31:0] req_address;
        logic [15:0] data_length;
        logic        source_valid;
        logic [7:0]  source_node;
        logic [7:0]  dest_node;
        logic        fixed_addr;
        logic        flit_valid;
        logic [7:0]  flit_index;
        logic [8:0]  flit_total;
        logic [15:0] request_tag;
    } req_t;

    // One result transaction as seen on the output ports.
    typedef struct {
        logic [31:0] address;
        logic [7:0]  dest_node;
        logic [1:0]  status;
    } alloc_t;

    localparam int RANGES   = 32;
    localparam int PENDINGS = 16;
    localparam int DRAIN_CYCLES = 1500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [21:0] i_cfg_wdata = '0;
    logic        i_start = 1'b0;
    logic        i_opcode = 1'b0;
    logic [31:0] i_req_address = '0;
    logic [15:0] i_data_length = '0;
    logic        i_source_valid = 1'b0;
    logic [7:0]  i_source_node = '0;
    logic [7:0]  i_dest_node = '0;
    logic        i_fixed_addr = 1'b0;
    logic        i_flit_valid = 1'b0;
    logic [7:0]  i_flit_index = '0;
    logic [8:0]  i_flit_total = 9'd1;
    logic [15:0] i_request_tag = '0;
    logic        o_busy;
    logic        o_done;
    logic [31:0] o_out_address;
    logic [7:0]  o_out_dest_node;
    logic [1:0]  o_status;

    chiplet_dynamic_address_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .i_start(i_start), .o_busy(o_busy),
        .i_opcode(i_opcode), .i_req_address(i_req_address),
        .i_data_length(i_data_length), .i_source_valid(i_source_valid),
        .i_source_node(i_source_node), .i_dest_node(i_dest_node),
        .i_fixed_addr(i_fixed_addr), .i_flit_valid(i_flit_valid),
        .i_flit_index(i_flit_index), .i_flit_total(i_flit_total),
        .i_request_tag(i_request_tag),
        .o_done(o_done), .o_out_address(o_out_address),
        .o_out_dest_node(o_out_dest_node), .o_status(o_status)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: configuration copy plus both tables.
    // ------------------------------------------------------------------
    logic [21:0] ram_kib_q  = cdaa_pkg::RAM_KIB_RST;
    logic [8:0]  flit_pb_q  = cdaa_pkg::FLIT_PB_RST;
    logic [31:0] rng_start [RANGES];
    logic [31:0] rng_len   [RANGES];
    bit          rng_vld   [RANGES];
    logic [15:0] pend_tag  [PENDINGS];
    logic [31:0] pend_base [PENDINGS];
    bit          pend_vld  [PENDINGS];

    req_t        pending_reqs [$];   // transactions waiting for the driver
    alloc_t      expected_allocs [$]; // predicted results, oldest first
    logic [31:0] granted_addrs [$];  // addresses handed out, used to build frees

    int n_accepted = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int n_oom = 0, n_full = 0, n_nopend = 0;
    int idle_pct = 0;

    function automatic longint unsigned half_bytes();
        return longint'(ram_kib_q) * 512;
    endfunction

    function automatic void free_at(logic [31:0] start);
        for (int i = 0; i < RANGES; i++)
            if (rng_vld[i] && rng_start[i] == start) rng_vld[i] = 0;
    endfunction

    // First-fit walk over ascending starts, then record the range.
    function automatic logic [31:0] place_range(bit onchip, longint unsigned size,
                                                output logic [1:0] st);
        longint unsigned base, lim, addr, last_start;
        bit have;
        int pick, slot;
        logic [31:0] key;
        base = onchip ? 0 : half_bytes();
        lim  = onchip ? half_bytes() : 2 * half_bytes();
        addr = base;
        last_start = 0;
        have = 0;
        while (1) begin
            pick = -1;
            for (int i = 0; i < RANGES; i++) begin
                // skip ranges below the region base and those already passed
                if (!rng_vld[i] || longint'(rng_start[i]) < base) continue;
                if (have && longint'(rng_start[i]) <= last_start) continue;
                if (pick < 0 || rng_start[i] < rng_start[pick]) pick = i;
            end
            if (pick < 0 || addr + size <= longint'(rng_start[pick])) break;
            addr = longint'(rng_start[pick]) + longint'(rng_len[pick]);
            last_start = rng_start[pick];
            have = 1;
        end
        key = addr[31:0];
        slot = -1;
        for (int i = 0; i < RANGES && slot < 0; i++)
            if (rng_vld[i] && rng_start[i] == key) slot = i;
        for (int i = 0; i < RANGES && slot < 0; i++)
            if (!rng_vld[i]) slot = i;
        if (slot >= 0) begin
            rng_vld[slot] = 1;
            rng_start[slot] = key;
            rng_len[slot] = size[31:0];
        end
        st = (slot < 0) ? cdaa_pkg::ST_FULL
                        : ((addr + size > lim) ? cdaa_pkg::ST_OOM : cdaa_pkg::ST_OK);
        return key;
    endfunction

    function automatic alloc_t predict_alloc(req_t r);
        alloc_t a;
        bit onchip;
        int slot;
        logic [1:0] st;
        logic [31:0] off_addr;
        onchip = !r.source_valid || r.source_node == r.dest_node;
        off_addr = 32'(longint'(r.req_address) + half_bytes());
        a.address = r.req_address;
        a.dest_node = r.dest_node;
        st = cdaa_pkg::ST_OK;
        if (onchip) begin
            if (r.opcode == cdaa_pkg::OP_READ) free_at(r.req_address);
            else if (r.flit_valid || !r.fixed_addr)
                a.address = place_range(1, r.data_length, st);
        end else if (r.opcode == cdaa_pkg::OP_READ) begin
            a.address = off_addr;
            free_at(off_addr);
            a.dest_node = r.source_node;
        end else if (r.fixed_addr) begin
            a.address = off_addr;
        end else if (r.flit_index == 0) begin
            a.address = place_range(0, longint'(flit_pb_q) * r.flit_total, st);
            slot = -1;
            for (int i = 0; i < PENDINGS && slot < 0; i++)
                if (pend_vld[i] && pend_tag[i] == r.request_tag) slot = i;
            for (int i = 0; i < PENDINGS && slot < 0; i++)
                if (!pend_vld[i]) slot = i;
            if (slot < 0) st = cdaa_pkg::ST_FULL;
            else begin
                pend_vld[slot] = 1;
                pend_tag[slot] = r.request_tag;
                pend_base[slot] = a.address;
            end
        end else begin
            slot = -1;
            for (int i = 0; i < PENDINGS && slot < 0; i++)
                if (pend_vld[i] && pend_tag[i] == r.request_tag) slot = i;
            if (slot < 0) begin
                st = cdaa_pkg::ST_NOPEND;
                a.address = '0;
            end else begin
                a.address = 32'(longint'(pend_base[slot]) +
                                longint'(r.flit_index) * flit_pb_q);
                // the last flit retires the tag
                if (int'(r.flit_index) + 1 == int'(r.flit_total)) pend_vld[slot] = 0;
            end
        end
        a.status = st;
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued transactions, hold them while busy.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        req_t r;
        alloc_t a;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                r.opcode = i_opcode; r.req_address = i_req_address;
                r.data_length = i_data_length; r.source_valid = i_source_valid;
                r.source_node = i_source_node; r.dest_node = i_dest_node;
                r.fixed_addr = i_fixed_addr; r.flit_valid = i_flit_valid;
                r.flit_index = i_flit_index; r.flit_total = i_flit_total;
                r.request_tag = i_request_tag;
                a = predict_alloc(r);
                expected_allocs.push_back(a);
                if (a.status == cdaa_pkg::ST_OK || a.status == cdaa_pkg::ST_OOM)
                    granted_addrs.push_back(a.address);
                n_accepted++;
            end
            // slot is free when nothing is held or the held one was just taken
            if (!i_start || !o_busy) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    r = pending_reqs.pop_front();
                    i_opcode <= r.opcode; i_req_address <= r.req_address;
                    i_data_length <= r.data_length; i_source_valid <= r.source_valid;
                    i_source_node <= r.source_node; i_dest_node <= r.dest_node;
                    i_fixed_addr <= r.fixed_addr; i_flit_valid <= r.flit_valid;
                    i_flit_index <= r.flit_index; i_flit_total <= r.flit_total;
                    i_request_tag <= r.request_tag;
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobed result must match the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        alloc_t a;
        if (i_rst_n && o_done) begin
            n_results++;
            if (expected_allocs.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: addr=%h dest=%h status=%0d",
                             o_out_address, o_out_dest_node, o_status);
            end else begin
                a = expected_allocs.pop_front();
                if (a.status == cdaa_pkg::ST_OOM) n_oom++;
                if (a.status == cdaa_pkg::ST_FULL) n_full++;
                if (a.status == cdaa_pkg::ST_NOPEND) n_nopend++;
                if (o_out_address !== a.address || o_out_dest_node !== a.dest_node ||
                    o_status !== a.status) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("result %0d: expected addr=%h dest=%h status=%0d, got addr=%h dest=%h status=%0d",
                                 n_results, a.address, a.dest_node, a.status,
                                 o_out_address, o_out_dest_node, o_status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic req_t noise_req();
        req_t r;
        r.opcode = 1'($urandom); r.req_address = $urandom;
        r.data_length = 16'($urandom);
        r.source_valid = 1'($urandom); r.source_node = 8'($urandom);
        r.dest_node = 8'($urandom);
        r.fixed_addr = 1'($urandom); r.flit_valid = 1'($urandom);
        r.flit_index = 8'($urandom);
        r.flit_total = 9'($urandom_range(256, 1)); r.request_tag = 16'($urandom);
        return r;
    endfunction

    function automatic req_t base_req(bit onchip, logic opc);
        req_t r;
        r = noise_req();
        r.opcode = opc;
        if (onchip) begin
            if ($urandom_range(1)) r.source_valid = 0;
            else begin r.source_valid = 1; r.dest_node = r.source_node; end
        end else begin
            r.source_valid = 1;
            if (r.dest_node == r.source_node) r.dest_node = ~r.source_node;
        end
        return r;
    endfunction

    // Wait until the block is idle and every prediction has been checked.
    task automatic drain();
        while (pending_reqs.size() > 0 || i_start || expected_allocs.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [21:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_wdata <= val;
        if (idx == cdaa_pkg::CFG_RAM_KIB) ram_kib_q = val;
        else if (idx == cdaa_pkg::CFG_FLIT_PB) flit_pb_q = val[8:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Queue one off-chip flit burst of one or more flits; optionally drop its tail.
    task automatic push_flit_burst();
        req_t r;
        int tot;
        bit broken;
        tot = ($urandom_range(15) == 0) ? $urandom_range(256, 1) : $urandom_range(6, 1);
        broken = ($urandom_range(9) == 0);
        r = base_req(0, cdaa_pkg::OP_WRITE);
        r.fixed_addr = 0; r.flit_valid = 1; r.flit_total = 9'(tot);
        for (int k = 0; k < tot && k < 8; k++) begin
            if (broken && k == tot - 1 && k > 0) break;
            // long bursts jump to their last flits to stay short
            r.flit_index = 8'((tot > 8 && k > 0) ? tot - 8 + k : k);
            r.data_length = 16'($urandom);
            pending_reqs.push_back(r);
        end
    endtask

    task automatic push_random();
        req_t r;
        int pick;
        longint unsigned h;
        pick = $urandom_range(99);
        h = half_bytes();
        if (pick < 25) begin
            r = base_req(1, cdaa_pkg::OP_WRITE);
            r.data_length = ($urandom_range(19) == 0) ? 16'hFFFF
                                                      : 16'($urandom_range(512));
            if (r.fixed_addr) r.flit_valid = 1;
            pending_reqs.push_back(r);
        end else if (pick < 33) begin
            r = base_req(1, cdaa_pkg::OP_WRITE);
            r.fixed_addr = 1; r.flit_valid = 0;
            pending_reqs.push_back(r);
        end else if (pick < 55 && granted_addrs.size() > 0) begin
            // free a previously granted range, from either side
            r.req_address = granted_addrs[$urandom_range(granted_addrs.size() - 1)];
            if (longint'(r.req_address) >= h) begin
                r = base_req(0, cdaa_pkg::OP_READ);
                r.req_address = granted_addrs[$urandom_range(granted_addrs.size() - 1)];
                r.req_address = 32'(longint'(r.req_address) - h);
            end else begin
                logic [31:0] ad;
                ad = r.req_address;
                r = base_req(1, cdaa_pkg::OP_READ);
                r.req_address = ad;
            end
            pending_reqs.push_back(r);
        end else if (pick < 82) begin
            push_flit_burst();
        end else if (pick < 88) begin
            r = base_req(0, cdaa_pkg::OP_WRITE);
            r.fixed_addr = 1;
            pending_reqs.push_back(r);
        end else begin
            pending_reqs.push_back(noise_req());
        end
    endtask

    task automatic push_directed();
        req_t r;
        // on-chip dynamic writes: zero length, largest length, length 64, flit-marked fixed
        r = base_req(1, cdaa_pkg::OP_WRITE); r.fixed_addr = 0; r.data_length = 16'd0;
        pending_reqs.push_back(r);
        r.data_length = 16'hFFFF; pending_reqs.push_back(r);
        r.data_length = 16'd64; pending_reqs.push_back(r);
        r.fixed_addr = 1; r.flit_valid = 1; r.data_length = 16'd100;
        pending_reqs.push_back(r);
        // on-chip fixed write at both address extremes
        r.flit_valid = 0; r.req_address = '0; pending_reqs.push_back(r);
        r.req_address = '1; pending_reqs.push_back(r);
        // off-chip fixed write that wraps past 2^32
        r = base_req(0, cdaa_pkg::OP_WRITE); r.fixed_addr = 1; r.req_address = '1;
        pending_reqs.push_back(r);
        // reads: on-chip at the start of the first range, and ones on either side that free nothing
        r = base_req(1, cdaa_pkg::OP_READ); r.req_address = '0; pending_reqs.push_back(r);
        r.req_address = 32'h1234_5679; pending_reqs.push_back(r);
        r = base_req(0, cdaa_pkg::OP_READ); r.req_address = '0; pending_reqs.push_back(r);
        r.req_address = '1; pending_reqs.push_back(r);
        // flit burst: single-flit total never retires, then a later flit hits it
        r = base_req(0, cdaa_pkg::OP_WRITE); r.fixed_addr = 0; r.flit_valid = 1;
        r.request_tag = 16'hFFFF; r.flit_total = 9'd1; r.flit_index = 8'd0;
        pending_reqs.push_back(r);
        r.flit_total = 9'd3; r.flit_index = 8'd0; pending_reqs.push_back(r); // overwrite tag
        r.flit_index = 8'd1; pending_reqs.push_back(r);
        r.flit_index = 8'd2; pending_reqs.push_back(r);
        r.flit_index = 8'd2; pending_reqs.push_back(r); // retired: no pending entry
        r.request_tag = 16'd0; r.flit_index = 8'd255; r.flit_total = 9'd256;
        pending_reqs.push_back(r);
        // fill the pending table past its end
        for (int k = 0; k < PENDINGS + 2; k++) begin
            r.request_tag = 16'(16'h100 + k); r.flit_index = 8'd0; r.flit_total = 9'd2;
            pending_reqs.push_back(r);
        end
    endtask

    task automatic run_phase(int n, int pct);
        idle_pct = pct;
        for (int k = 0; k < n; k++) begin
            while (pending_reqs.size() > 3) @(posedge i_clk);
            push_random();
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequencer: reset, directed part, then phases with several settings.
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < RANGES; i++) begin rng_vld[i] = 0; rng_start[i] = 0; rng_len[i] = 0; end
        for (int i = 0; i < PENDINGS; i++) begin pend_vld[i] = 0; pend_tag[i] = 0; pend_base[i] = 0; end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_directed();
        drain();
        run_phase(150, 0);

        // a small RAM and one-byte flits, to provoke out-of-memory results
        cfg_write(cdaa_pkg::CFG_RAM_KIB, 22'd2);
        cfg_write(cdaa_pkg::CFG_FLIT_PB, 22'd1);
        cfg_write(2'd2, 22'h3FFFFF);    // index past the list: ignored
        granted_addrs.delete();
        run_phase(150, 75);

        // largest RAM, flit payload of 256: off-chip sums run past 2^32
        cfg_write(cdaa_pkg::CFG_RAM_KIB, 22'h3FFFFF);
        cfg_write(cdaa_pkg::CFG_FLIT_PB, 22'd256);
        granted_addrs.delete();
        run_phase(150, 10);

        cfg_write(cdaa_pkg::CFG_RAM_KIB, 22'($urandom_range(8, 2)));
        cfg_write(cdaa_pkg::CFG_FLIT_PB, 22'($urandom_range(256, 1)));
        granted_addrs.delete();
        run_phase(150, 0);

        cfg_write(cdaa_pkg::CFG_RAM_KIB, cdaa_pkg::RAM_KIB_RST);
        cfg_write(cdaa_pkg::CFG_FLIT_PB, 22'(cdaa_pkg::FLIT_PB_RST));
        granted_addrs.delete();
        run_phase(150, 75);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_allocs.size() > 0) n_mismatch += expected_allocs.size();
        $display("covered %0d transactions, %0d results checked across five settings",
                 n_accepted, n_results);
        $display("statuses seen: %0d out of memory, %0d table full, %0d no pending entry",
                 n_oom, n_full, n_nopend);
        if (n_mismatch == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #400_000_000;
        $display("timeout");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
